// File: hdl/seeded_crc32_report_check_macros.svh
// Assertion macros shared by the report checker modules.
`ifndef SEEDED_CRC32_REPORT_CHECK_MACROS_SVH
`define SEEDED_CRC32_REPORT_CHECK_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, switched off while reset is high.
`define SCRC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("scrc assertion failed");

// Clocked property that must also hold during reset.
`define SCRC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("scrc assertion failed");

`else

`define SCRC_ASSERT(lbl, clk, rst, prop)
`define SCRC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: hdl/scrc_pkg.sv
`default_nettype none
package scrc_pkg;

   localparam int CRC_W  = 32;
   localparam int BYTE_W = 8;

   localparam logic [CRC_W-1:0]  CRC_POLY   = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0]  CRC_ONES   = 32'hFFFF_FFFF;
   localparam logic [BYTE_W-1:0] SEED_RESET = 8'd161;

   // One input word.
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
      logic [CRC_W-1:0]  expected_crc;
   } req_payload_type;

   // One result word.
   typedef struct packed {
      logic [CRC_W-1:0] crc_value;
      logic             crc_match;
   } rsp_payload_type;

   // Control shared by every cell of the row.
   typedef struct packed {
      logic step;     // a word is accepted this cycle
      logic restart;  // that word closes the report
      logic start;    // the report opens with this word
   } cell_ctrl_type;

   // Reflected CRC-32 update over one byte, one bit per step.
   function automatic logic [CRC_W-1:0] crc_fold_byte(input logic [CRC_W-1:0]  crc,
                                                       input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Byte table entry: the CRC contribution of the low byte after eight shifts.
   function automatic logic [CRC_W-1:0] crc_table_entry(input logic [BYTE_W-1:0] idx);
      return crc_fold_byte({CRC_W{1'b0}}, idx);
   endfunction

   // Report start value for the reset seed.
   localparam logic [CRC_W-1:0] SEEDED_RESET = crc_fold_byte(CRC_ONES, SEED_RESET);

endpackage
`default_nettype wire

// File: hdl/seeded_crc32_report_check.sv
// Seeded CRC-32 report checker (reflected IEEE 802.3 CRC).
// req channel: one report byte per word with a last flag and the expected
// CRC, which is only looked at on the last word. A report has at least one word.
// rsp channel: one word per report, the complemented CRC over the seed byte
// and the report bytes, with a flag that is set when it equals the expected CRC.
// csr channel: writes the seed byte; always ready. Write it only while no
// report is in progress and no result is pending.
// Throughput: one word per cycle while req_ready is high; a 32-cell row updates
// the CRC a byte at a time, so consecutive words need no gap.
// Result: the result is registered and valid in the cycle after its last word is accepted.
// Stalls: the result sits in an output register; req_ready drops only while
// that register is full and rsp_ready is low, and it stays open otherwise.
// Reset: the seed returns to 161, the running CRC to all ones, the next word
// opens a report, and no result is pending.
`default_nettype none
module seeded_crc32_report_check (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire scrc_pkg::req_payload_type     req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output scrc_pkg::rsp_payload_type          rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [scrc_pkg::BYTE_W-1:0]   csr_wdata
);
   import scrc_pkg::*;

   `include "seeded_crc32_report_check_macros.svh"

   logic             csr_write;
   logic [CRC_W-1:0] seeded_ff;
   logic [CRC_W-1:0] seeded_in;
   logic             req_acc;
   logic             close_acc;
   logic [CRC_W-1:0] crc_next;
   logic [CRC_W-1:0] crc_final;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_payload_type  rsp_data_ff;
   rsp_payload_type  rsp_data_in;

   // Configuration: keep the seed already folded into the all-ones start value.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign seeded_in = csr_write ? crc_fold_byte(CRC_ONES, csr_wdata) : seeded_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= SEEDED_RESET;
      end else begin
         seeded_ff <= seeded_in;
      end
   end

   // Input handshake: blocked only by a full, stalled output register.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_acc   = req_valid && req_ready;
   assign close_acc = req_acc && req_data.last_byte;

   scrc_row u_row (
      .clock     (clock),
      .reset     (reset),
      .step      (req_acc),
      .last      (req_data.last_byte),
      .data_byte (req_data.data_byte),
      .seeded    (seeded_ff),
      .crc_next  (crc_next)
   );

   // Result word for a closing byte.
   assign crc_final             = ~crc_next;
   assign rsp_data_in.crc_value = crc_final;
   assign rsp_data_in.crc_match = (crc_final == req_data.expected_crc);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (close_acc) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (close_acc) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SCRC_ASSERT(a_close_gives_result, clock, reset, close_acc |=> rsp_valid)
   `SCRC_ASSERT(a_open_when_empty, clock, reset, !rsp_valid_ff |-> req_ready)
   `SCRC_ASSERT(a_match_flag, clock, reset,
      close_acc |=> (rsp_data.crc_match == (rsp_data.crc_value == $past(req_data.expected_crc))))

endmodule
`default_nettype wire

// File: hdl/scrc_cell.sv
`default_nettype none
module scrc_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire scrc_pkg::cell_ctrl_type ctrl,
   input  wire logic                 seed_bit,
   input  wire logic                 upper_bit,
   input  wire logic                 tab_bit,
   output logic                      cur_bit,
   output logic                      next_bit
);
   import scrc_pkg::*;

   logic run_ff;
   logic run_in;

   // At the first word of a report the bit comes from the seeded start value.
   assign cur_bit  = ctrl.start ? seed_bit : run_ff;

   // Byte update: the bit eight places up moves here, plus the table term.
   assign next_bit = upper_bit ^ tab_bit;

   // A closing word rearms the bit to one.
   always_comb begin
      run_in = run_ff;
      if (ctrl.step) begin
         run_in = ctrl.restart ? 1'b1 : next_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b1;
      end else begin
         run_ff <= run_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/scrc_row.sv
`default_nettype none
module scrc_row (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic                          last,
   input  wire logic [scrc_pkg::BYTE_W-1:0]   data_byte,
   input  wire logic [scrc_pkg::CRC_W-1:0]    seeded,
   output logic      [scrc_pkg::CRC_W-1:0]    crc_next
);
   import scrc_pkg::*;

   `include "seeded_crc32_report_check_macros.svh"

   logic             start_ff;
   logic             start_in;
   cell_ctrl_type    ctrl;
   logic [CRC_W-1:0] cur;
   logic [CRC_W-1:0] tab;

   // The start flag is set by a closing word and cleared by any other word.
   assign start_in = step ? last : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
      end else begin
         start_ff <= start_in;
      end
   end

   assign ctrl.step    = step;
   assign ctrl.restart = last;
   assign ctrl.start   = start_ff;

   // Table term indexed by the low byte of the current CRC and the data.
   assign tab = crc_table_entry(cur[BYTE_W-1:0] ^ data_byte);

   // One cell per CRC bit; each below the top byte takes the bit eight places up.
   for (genvar i = 0; i < CRC_W; i++) begin : g_cell
      logic upper;
      if (i < CRC_W - BYTE_W) begin : g_mid
         assign upper = cur[i+BYTE_W];
      end else begin : g_top
         assign upper = 1'b0;
      end
      scrc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .seed_bit  (seeded[i]),
         .upper_bit (upper),
         .tab_bit   (tab[i]),
         .cur_bit   (cur[i]),
         .next_bit  (crc_next[i])
      );
   end

   `SCRC_ASSERT_ALWAYS(a_reset_opens, clock, reset |=> start_ff)
   `SCRC_ASSERT(a_rearm, clock, reset, step && last |=> start_ff)
   `SCRC_ASSERT(a_mid_report, clock, reset, step && !last |=> !start_ff)

endmodule
`default_nettype wire
